@@ sv/ppcsq_pkg.sv @@
`timescale 1ns / 1ps
package ppcsq_pkg;
   localparam int FUNC_BITS = 3;
   localparam int CNT_BITS  = 7;
   localparam int ORD_BITS  = 2;
   localparam int IDX_BITS  = 6;
   localparam int MASK_BITS = 64;
   localparam int VAL_BITS  = 32;

   typedef enum logic [2:0] {
      FN_PUSH    = 3'd0,
      FN_COMPACT = 3'd1,
      FN_PUBLISH = 3'd2,
      FN_RELEASE = 3'd3,
      FN_RD_PEND = 3'd4,
      FN_RD_WR   = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_PENDING = 3'd2,
      ST_NONE    = 3'd3,
      ST_ORDER   = 3'd4,
      ST_COUNT   = 3'd5,
      ST_INDEX   = 3'd6,
      ST_FUNC    = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_WAIT,
      S_CMP_RD,
      S_CMP_WR,
      S_SORT_INIT,
      S_SORT_RD,
      S_SORT_VAL,
      S_SORT_CMP,
      S_SORT_SHIFT,
      S_SORT_PLACE,
      S_DONE
   } state_type;

   localparam logic [1:0] ORD_KEEP = 2'd0;
   localparam logic [1:0] ORD_SORT = 2'd1;

   typedef struct packed {
      logic load_v;
      logic load_prev;
   } ctl_type;
endpackage

@@ sv/ppcsq_store.sv @@
`timescale 1ns / 1ps
module ppcsq_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(2*DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic [$clog2(2*DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]           rdata
);
   logic [WIDTH-1:0] mem [2*DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end
endmodule

@@ sv/ping_pong_compacting_slot_queue_unit.sv @@
`timescale 1ns / 1ps
// Two slot buffers used ping-pong, held in one single-port-read memory. Push, publish, release
// and every request refused at once are answered from the idle state; entry reads take longer because
// the memory read is registered and the result passes through a finishing state. Compaction
// walks the write buffer once, one memory read per entry and one write per kept entry;
// sort mode then runs an insertion sort over the kept entries through the same memory port and
// one shared comparator. The request side is not ready while a request is in work or a
// response waits to be taken.
module ping_pong_compacting_slot_queue_unit #(
   parameter int QUEUE_DEPTH = 64,
   parameter int SLOT_BITS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [ppcsq_pkg::CNT_BITS-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ppcsq_pkg::FUNC_BITS-1:0]   req_func,
   input  logic [ppcsq_pkg::VAL_BITS-1:0]    req_slot_value,
   input  logic [ppcsq_pkg::MASK_BITS-1:0]   req_active_mask,
   input  logic [ppcsq_pkg::CNT_BITS-1:0]    req_lane_count,
   input  logic [ppcsq_pkg::ORD_BITS-1:0]    req_order_mode,
   input  logic [ppcsq_pkg::IDX_BITS-1:0]    req_entry_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [ppcsq_pkg::VAL_BITS-1:0]    rsp_entry_value,
   output logic [ppcsq_pkg::CNT_BITS-1:0]    rsp_lanes_in,
   output logic [ppcsq_pkg::CNT_BITS-1:0]    rsp_lanes_kept,
   output logic [ppcsq_pkg::CNT_BITS-1:0]    rsp_lanes_dropped,
   output logic [ppcsq_pkg::CNT_BITS-1:0]    rsp_write_count,
   output logic [ppcsq_pkg::CNT_BITS-1:0]    rsp_read_count,
   output logic                              rsp_pending_flag
);
   import ppcsq_pkg::*;

   localparam int PB = $clog2(QUEUE_DEPTH) > 0 ? $clog2(QUEUE_DEPTH) : 1;
   localparam int AB = $clog2(2*QUEUE_DEPTH);
   localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(QUEUE_DEPTH);

   state_type state_ff, state_in;
   ctl_type   ctl;

   logic [CNT_BITS-1:0]  cap_ff;
   logic [CNT_BITS-1:0]  fill_ff [2];
   logic                 rsel_ff, pend_ff;
   logic [FUNC_BITS-1:0] func_ff;
   logic [MASK_BITS-1:0] mask_ff;
   logic [ORD_BITS-1:0]  ord_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic                 rspv_ff;
   logic [2:0]           st_ff;
   logic [VAL_BITS-1:0]  val_ff;
   logic [CNT_BITS-1:0]  nin_ff, nact_ff;
   logic [CNT_BITS-1:0]  i_ff, kept_ff, j_ff;
   logic [SLOT_BITS-1:0] v_ff, prev_ff;

   logic                 wsel;
   logic [CNT_BITS-1:0]  wfill, eff_cap;
   logic                 mem_we;
   logic [AB-1:0]        waddr, raddr;
   logic [SLOT_BITS-1:0] wdata, rdata;
   logic                 accept;
   logic                 rd_buf;
   logic                 rd_bad;

   assign wsel    = ~rsel_ff;
   assign wfill   = fill_ff[wsel];
   assign eff_cap = (cap_ff > DEPTH_C) ? DEPTH_C : cap_ff;
   assign accept  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rd_buf  = (func_ff == FN_RD_PEND) ? rsel_ff : wsel;
   assign rd_bad  = ({1'b0, idx_ff} >= fill_ff[rd_buf]) || ({1'b0, idx_ff} >= DEPTH_C);

   function automatic logic [AB-1:0] addr_of(input logic b, input logic [CNT_BITS-1:0] p);
      logic [AB:0] t;
      t = (AB+1)'(b) * (AB+1)'(QUEUE_DEPTH) + (AB+1)'(p[PB-1:0]);
      return t[AB-1:0];
   endfunction

   ppcsq_store #(.DEPTH(QUEUE_DEPTH), .WIDTH(SLOT_BITS)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_func == FN_COMPACT && req_order_mode <= ORD_SORT &&
                            req_lane_count == wfill) begin
                  state_in = (wfill == '0) ? S_DONE : S_CMP_RD;
               end else if ((req_func == FN_RD_PEND && pend_ff) || req_func == FN_RD_WR) begin
                  state_in = S_RD_WAIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RD_WAIT:    state_in = S_DONE;
         S_CMP_RD:     state_in = S_CMP_WR;
         S_CMP_WR:     state_in = (i_ff + 1'b1 >= nin_ff) ?
                                  ((ord_ff == ORD_SORT) ? S_SORT_INIT : S_DONE) : S_CMP_RD;
         S_SORT_INIT:  state_in = (kept_ff <= 7'd1) ? S_DONE : S_SORT_RD;
         S_SORT_RD:    state_in = S_SORT_VAL;
         S_SORT_VAL:   state_in = S_SORT_CMP;
         S_SORT_CMP:   state_in = (j_ff != '0 && rdata > v_ff) ? S_SORT_SHIFT : S_SORT_PLACE;
         S_SORT_SHIFT: state_in = S_SORT_CMP;
         S_SORT_PLACE: state_in = (i_ff + 1'b1 >= kept_ff) ? S_DONE : S_SORT_RD;
         S_DONE:       state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl    = '0;
      waddr  = addr_of(wsel, wfill);
      wdata  = SLOT_BITS'(req_slot_value);
      raddr  = addr_of(rd_buf, {1'b0, idx_ff});
      mem_we = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            raddr  = addr_of(req_func == FN_RD_PEND ? rsel_ff : wsel, {1'b0, req_entry_index});
            mem_we = accept && req_func == FN_PUSH && wfill < eff_cap;
         end
         S_CMP_RD:  raddr = addr_of(wsel, i_ff);
         S_CMP_WR: begin
            waddr  = addr_of(wsel, kept_ff);
            wdata  = rdata;
            mem_we = mask_ff[i_ff[PB-1:0]];
         end
         S_SORT_RD: raddr = addr_of(wsel, i_ff);
         S_SORT_VAL: begin
            raddr      = addr_of(wsel, j_ff - 1'b1);
            ctl.load_v = 1'b1;
         end
         S_SORT_CMP: ctl.load_prev = 1'b1;
         S_SORT_SHIFT: begin
            waddr  = addr_of(wsel, j_ff);
            wdata  = prev_ff;
            mem_we = 1'b1;
            raddr  = addr_of(wsel, j_ff - 7'd2);
         end
         S_SORT_PLACE: begin
            waddr  = addr_of(wsel, j_ff);
            wdata  = v_ff;
            mem_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff   <= 7'd64;
         fill_ff[0] <= '0;
         fill_ff[1] <= '0;
         rsel_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (rspv_ff && rsp_ready) begin
            rspv_ff <= 1'b0;
         end
         if (state_ff == S_IDLE && accept) begin
            func_ff  <= req_func;
            mask_ff  <= req_active_mask;
            ord_ff   <= req_order_mode;
            idx_ff   <= req_entry_index;
            val_ff   <= '0;
            nin_ff   <= '0;
            nact_ff  <= '0;
            i_ff     <= '0;
            kept_ff  <= '0;
            st_ff    <= ST_OK;
            unique case (req_func)
               FN_PUSH: begin
                  rspv_ff <= 1'b1;
                  if (wfill >= eff_cap) begin
                     st_ff <= ST_FULL;
                  end else begin
                     fill_ff[wsel] <= wfill + 1'b1;
                  end
               end
               FN_COMPACT: begin
                  if (req_order_mode > ORD_SORT) begin
                     st_ff <= ST_ORDER;
                     rspv_ff <= 1'b1;
                  end else if (req_lane_count != wfill) begin
                     st_ff <= ST_COUNT;
                     rspv_ff <= 1'b1;
                  end else begin
                     nin_ff <= wfill;
                  end
               end
               FN_PUBLISH: begin
                  rspv_ff <= 1'b1;
                  if (pend_ff) begin
                     st_ff <= ST_PENDING;
                  end else begin
                     rsel_ff <= wsel;
                     pend_ff <= 1'b1;
                  end
               end
               FN_RELEASE: begin
                  rspv_ff <= 1'b1;
                  if (!pend_ff) begin
                     st_ff <= ST_NONE;
                  end else begin
                     fill_ff[rsel_ff] <= '0;
                     pend_ff <= 1'b0;
                  end
               end
               FN_RD_PEND: begin
                  if (!pend_ff) begin
                     st_ff <= ST_NONE;
                     rspv_ff <= 1'b1;
                  end
               end
               FN_RD_WR: ;
               default: begin
                  st_ff <= ST_FUNC;
                  rspv_ff <= 1'b1;
               end
            endcase
         end
         unique case (state_ff)
            S_RD_WAIT: begin
               if (rd_bad) begin
                  st_ff <= ST_INDEX;
               end else begin
                  val_ff <= VAL_BITS'(rdata);
               end
            end
            S_CMP_WR: begin
               i_ff <= i_ff + 1'b1;
               if (mask_ff[i_ff[PB-1:0]]) begin
                  kept_ff <= kept_ff + 1'b1;
               end
            end
            S_SORT_INIT: i_ff <= 7'd1;
            S_SORT_RD:   j_ff <= i_ff;
            S_SORT_SHIFT: j_ff <= j_ff - 1'b1;
            S_SORT_PLACE: i_ff <= i_ff + 1'b1;
            S_DONE: begin
               rspv_ff <= 1'b1;
               if (func_ff == FN_COMPACT) begin
                  fill_ff[wsel] <= kept_ff;
                  nact_ff <= kept_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Sort registers: the entry being inserted (compared) and the neighbour entry shifted up a slot.
   always_ff @(posedge clock) begin
      if (ctl.load_v) begin
         v_ff <= rdata;
      end
      if (ctl.load_prev) begin
         prev_ff <= rdata;
      end
   end

   assign rsp_valid         = rspv_ff;
   assign rsp_status        = st_ff;
   assign rsp_entry_value   = val_ff;
   assign rsp_lanes_in      = nin_ff;
   assign rsp_lanes_kept    = nact_ff;
   assign rsp_lanes_dropped = (st_ff == ST_OK && func_ff == FN_COMPACT) ?
                              nin_ff - nact_ff : '0;
   assign rsp_write_count   = fill_ff[~rsel_ff];
   assign rsp_read_count    = fill_ff[rsel_ff];
   assign rsp_pending_flag  = pend_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("request taken while a response waits");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff != S_IDLE) |-> !req_ready)
      else $error("ready during a walk");
   assert property (@(posedge clock) disable iff (reset)
                    fill_ff[0] <= DEPTH_C && fill_ff[1] <= DEPTH_C)
      else $error("fill beyond depth");
endmodule

@@ tb/ping_pong_compacting_slot_queue_unit_test.sv @@
`timescale 1ns / 1ps
module ping_pong_compacting_slot_queue_unit_test;
   import ppcsq_pkg::*;

   localparam int DEPTH = 64;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] slot_value;
      logic [63:0] active_mask;
      logic [6:0]  lane_count;
      logic [1:0]  order_mode;
      logic [5:0]  entry_index;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] entry_value;
      logic [6:0]  lanes_in;
      logic [6:0]  lanes_kept;
      logic [6:0]  lanes_dropped;
      logic [6:0]  write_count;
      logic [6:0]  read_count;
      logic        pending_flag;
   } response_type;

   typedef struct {
      request_type  req;
      logic         typed;
      response_type rsp;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [6:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_ready;
   request_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   response_type rsp_item;

   ping_pong_compacting_slot_queue_unit uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_item.func), .req_slot_value(req_item.slot_value),
      .req_active_mask(req_item.active_mask), .req_lane_count(req_item.lane_count),
      .req_order_mode(req_item.order_mode), .req_entry_index(req_item.entry_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_item.status), .rsp_entry_value(rsp_item.entry_value),
      .rsp_lanes_in(rsp_item.lanes_in), .rsp_lanes_kept(rsp_item.lanes_kept),
      .rsp_lanes_dropped(rsp_item.lanes_dropped),
      .rsp_write_count(rsp_item.write_count), .rsp_read_count(rsp_item.read_count),
      .rsp_pending_flag(rsp_item.pending_flag)
   );

   logic [31:0] slots [2][DEPTH];
   int unsigned fill [2];
   int unsigned rd_sel;
   logic        pending;
   int unsigned capacity;

   response_type expected_responses [$];
   int errors = 0;
   int idle_cycles = 0;
   logic rsp_idle_enable = 1;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic response_type queue_step(request_type r);
      response_type o;
      int unsigned w;
      int unsigned b;
      int unsigned cap;
      int unsigned n;
      int unsigned kept;
      int j;
      logic [31:0] v;
      o = '0;
      w = 1 - rd_sel;
      cap = capacity > DEPTH ? DEPTH : capacity;
      o.status = ST_OK;
      case (r.func)
         FN_PUSH: begin
            if (fill[w] >= cap) begin
               o.status = ST_FULL;
            end else begin
               slots[w][fill[w]] = r.slot_value;
               fill[w]++;
            end
         end
         FN_COMPACT: begin
            if (r.order_mode > ORD_SORT) begin
               o.status = ST_ORDER;
            end else if (r.lane_count != fill[w]) begin
               o.status = ST_COUNT;
            end else begin
               n = fill[w];
               kept = 0;
               for (int i = 0; i < n; i++) begin
                  if (r.active_mask[i]) begin
                     slots[w][kept] = slots[w][i];
                     kept++;
                  end
               end
               if (r.order_mode == ORD_SORT) begin
                  for (int i = 1; i < kept; i++) begin
                     v = slots[w][i];
                     j = i;
                     while (j > 0 && slots[w][j-1] > v) begin
                        slots[w][j] = slots[w][j-1];
                        j--;
                     end
                     slots[w][j] = v;
                  end
               end
               fill[w] = kept;
               o.lanes_in = 7'(n);
               o.lanes_kept = 7'(kept);
               o.lanes_dropped = 7'(n - kept);
            end
         end
         FN_PUBLISH: begin
            if (pending) begin
               o.status = ST_PENDING;
            end else begin
               rd_sel = w;
               pending = 1;
            end
         end
         FN_RELEASE: begin
            if (!pending) begin
               o.status = ST_NONE;
            end else begin
               fill[rd_sel] = 0;
               pending = 0;
            end
         end
         FN_RD_PEND, FN_RD_WR: begin
            b = (r.func == FN_RD_PEND) ? rd_sel : w;
            if (r.func == FN_RD_PEND && !pending) begin
               o.status = ST_NONE;
            end else if (r.entry_index >= fill[b]) begin
               o.status = ST_INDEX;
            end else begin
               o.entry_value = slots[b][r.entry_index];
            end
         end
         default: o.status = ST_FUNC;
      endcase
      o.write_count = 7'(fill[1 - rd_sel]);
      o.read_count = 7'(fill[rd_sel]);
      o.pending_flag = pending;
      return o;
   endfunction

   task automatic send_request(request_type r, logic idle_enable);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_item <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(int unsigned value);
      drain_responses();
      csr_write_enable <= 1;
      csr_write_data <= 7'(value);
      @(posedge clock);
      csr_write_enable <= 0;
      capacity = value;
   endtask

   function automatic request_type make_request(logic [2:0] f);
      request_type r;
      r.func = f;
      r.slot_value = $urandom();
      r.active_mask = {$urandom(), $urandom()};
      r.lane_count = 7'($urandom_range(0, 127));
      r.order_mode = 2'($urandom_range(0, 3));
      r.entry_index = 6'($urandom());
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int unsigned pick;
      int unsigned w;
      pick = $urandom_range(0, 99);
      w = 1 - rd_sel;
      if (pick < 40) begin
         r = make_request(FN_PUSH);
         if ($urandom_range(0, 3) == 0) r.slot_value = $urandom_range(0, 7);
      end else if (pick < 55) begin
         r = make_request(FN_COMPACT);
         if ($urandom_range(0, 7) != 0) begin
            r.lane_count = 7'(fill[w]);
            r.order_mode = 2'($urandom_range(0, 1));
         end
         if ($urandom_range(0, 7) == 0) r.active_mask = '1;
      end else if (pick < 65) begin
         r = make_request(FN_PUBLISH);
      end else if (pick < 75) begin
         r = make_request(FN_RELEASE);
      end else if (pick < 95) begin
         r = make_request($urandom_range(0, 1) ? FN_RD_PEND : FN_RD_WR);
         if ($urandom_range(0, 4) != 0) begin
            r.entry_index = 6'($urandom_range(0, 63) % ((r.func == FN_RD_PEND ? fill[rd_sel]
                                                                    : fill[w]) + 1));
         end
      end else begin
         r = make_request(3'($urandom_range(6, 7)));
      end
      return r;
   endfunction

   task automatic run_request(request_type r, logic idle_enable);
      expected_responses.push_back(queue_step(r));
      send_request(r, idle_enable);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (idle_cycles > 0) begin
         idle_cycles--;
         rsp_ready <= 0;
      end else if (rsp_idle_enable && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 0;
         idle_cycles = $urandom_range(0, 17);
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      response_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $error("response with none expected");
            errors++;
         end else begin
            exp_rsp = expected_responses.pop_front();
            if (rsp_item.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_item.status);
               errors++;
            end
            if (rsp_item.entry_value !== exp_rsp.entry_value) begin
               $error("entry_value exp %0h got %0h", exp_rsp.entry_value, rsp_item.entry_value);
               errors++;
            end
            if (rsp_item.lanes_in !== exp_rsp.lanes_in) begin
               $error("lanes_in exp %0d got %0d", exp_rsp.lanes_in, rsp_item.lanes_in);
               errors++;
            end
            if (rsp_item.lanes_kept !== exp_rsp.lanes_kept) begin
               $error("lanes_kept exp %0d got %0d", exp_rsp.lanes_kept,
                      rsp_item.lanes_kept);
               errors++;
            end
            if (rsp_item.lanes_dropped !== exp_rsp.lanes_dropped) begin
               $error("lanes_dropped exp %0d got %0d", exp_rsp.lanes_dropped,
                      rsp_item.lanes_dropped);
               errors++;
            end
            if (rsp_item.write_count !== exp_rsp.write_count) begin
               $error("write_count exp %0d got %0d", exp_rsp.write_count, rsp_item.write_count);
               errors++;
            end
            if (rsp_item.read_count !== exp_rsp.read_count) begin
               $error("read_count exp %0d got %0d", exp_rsp.read_count, rsp_item.read_count);
               errors++;
            end
            if (rsp_item.pending_flag !== exp_rsp.pending_flag) begin
               $error("pending_flag exp %0d got %0d", exp_rsp.pending_flag,
                      rsp_item.pending_flag);
               errors++;
            end
         end
      end
   end

   int stall_count = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count = 0;
      end else if (!reset && !csr_write_enable) begin
         stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic row_type row(logic [2:0] f, logic [31:0] v, logic [63:0] m,
                                   logic [6:0] n, logic [1:0] o, logic [5:0] x, logic typed,
                                   response_type e);
      row_type t;
      t.req = '{func: f, slot_value: v, active_mask: m, lane_count: n, order_mode: o,
                entry_index: x};
      t.typed = typed;
      t.rsp = e;
      return t;
   endfunction

   row_type directed [$];

   initial begin
      response_type got;
      capacity = 64;
      fill[0] = 0;
      fill[1] = 0;
      rd_sel = 0;
      pending = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed rows straight after reset; some carry a known answer, the rest are checked against queue_step.
      directed.push_back(row(FN_RELEASE, 0, 0, 0, 0, 0, 1,
                             '{ST_NONE, 0, 0, 0, 0, 0, 0, 0}));
      directed.push_back(row(FN_RD_PEND, 0, 0, 0, 0, 0, 1,
                             '{ST_NONE, 0, 0, 0, 0, 0, 0, 0}));
      directed.push_back(row(FN_RD_WR, 0, 0, 0, 0, 63, 1,
                             '{ST_INDEX, 0, 0, 0, 0, 0, 0, 0}));
      directed.push_back(row(3'd6, 0, 0, 0, 0, 0, 1, '{ST_FUNC, 0, 0, 0, 0, 0, 0, 0}));
      directed.push_back(row(3'd7, 0, 0, 0, 0, 0, 1, '{ST_FUNC, 0, 0, 0, 0, 0, 0, 0}));
      directed.push_back(row(FN_COMPACT, 0, 0, 0, 2'd3, 0, 1,
                             '{ST_ORDER, 0, 0, 0, 0, 0, 0, 0}));
      directed.push_back(row(FN_PUSH, 32'hFFFFFFFF, 0, 0, 0, 0, 1,
                             '{ST_OK, 0, 0, 0, 0, 1, 0, 0}));
      directed.push_back(row(FN_PUSH, 32'h0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 2, 0, 0}));
      directed.push_back(row(FN_PUSH, 32'h5, 0, 0, 0, 0, 0, '0));
      directed.push_back(row(FN_RD_WR, 0, 0, 0, 0, 0, 1,
                             '{ST_OK, 32'hFFFFFFFF, 0, 0, 0, 3, 0, 0}));
      directed.push_back(row(FN_COMPACT, 0, 0, 2, 0, 0, 1,
                             '{ST_COUNT, 0, 0, 0, 0, 3, 0, 0}));
      directed.push_back(row(FN_COMPACT, 0, '1, 3, ORD_SORT, 0, 0, '0));
      directed.push_back(row(FN_RD_WR, 0, 0, 0, 0, 2, 0, '0));
      directed.push_back(row(FN_COMPACT, 0, 64'hFFFF_FFFF_FFFF_FFFA, 3, ORD_KEEP, 0, 0, '0));
      directed.push_back(row(FN_PUBLISH, 0, 0, 0, 0, 0, 0, '0));
      directed.push_back(row(FN_PUBLISH, 0, 0, 0, 0, 0, 0, '0));
      directed.push_back(row(FN_RD_PEND, 0, 0, 0, 0, 0, 0, '0));
      directed.push_back(row(FN_RD_PEND, 0, 0, 0, 0, 1, 0, '0));
      directed.push_back(row(FN_COMPACT, 0, 0, 0, ORD_SORT, 0, 0, '0));
      directed.push_back(row(FN_RELEASE, 0, 0, 0, 0, 0, 0, '0));
      foreach (directed[i]) begin
         got = queue_step(directed[i].req);
         expected_responses.push_back(directed[i].typed ? directed[i].rsp : got);
         send_request(directed[i].req, 1);
      end

      // Zero capacity, then a small one that is later lowered below the fill.
      write_capacity(0);
      run_request(make_request(FN_PUSH), 1);
      write_capacity(3);
      repeat (5) run_request(make_request(FN_PUSH), 1);
      write_capacity(1);
      run_request(make_request(FN_PUSH), 1);
      run_request(make_request(FN_RD_WR), 1);
      write_capacity(127);
      for (int i = 0; i < 70; i++) run_request(make_request(FN_PUSH), 0);
      begin
         request_type r;
         r = make_request(FN_COMPACT);
         r.lane_count = 7'(fill[1 - rd_sel]);
         r.order_mode = ORD_SORT;
         r.active_mask = '1;
         run_request(r, 0);
      end

      for (int phase = 0; phase < 4; phase++) begin
         write_capacity(phase == 0 ? 64 : phase == 1 ? 8 : phase == 2 ? 65 : 20);
         for (int i = 0; i < 160; i++) run_request(random_request(), 1);
      end
      // The sender holds off until every expected response is back.
      drain_responses();
      rsp_idle_enable <= 0;
      for (int i = 0; i < 100; i++) run_request(random_request(), 0);

      drain_responses();
      if (errors == 0 && expected_responses.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

@@ files.f @@
sv/ppcsq_pkg.sv
sv/ppcsq_store.sv
sv/ping_pong_compacting_slot_queue_unit.sv
tb/ping_pong_compacting_slot_queue_unit_test.sv
